// ===== rtl/glmf_pkg.sv =====
package glmf_pkg;

    localparam int CFG_DATA_W  = 10;
    localparam int CFG_INDEX_W = 2;
    localparam int PEAK_W      = 9;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t CFG_NUM_ROWS = 2'd0;
    localparam cfg_index_t CFG_NUM_COLS = 2'd1;

    typedef struct packed {
        logic flush;
        logic decide;
        logic has_up;
        logic has_left;
        logic has_right;
    } item_flags_t;

endpackage

// ===== rtl/glmf_frame_ctrl.sv =====
module glmf_frame_ctrl #(
    parameter int MAX_ROWS = 512,
    parameter int MAX_COLS = 512
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  glmf_pkg::cfg_index_t              cfg_index,
    input  logic [glmf_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              pixel_valid,
    input  logic                              op,
    input  logic                              pixel_stall,
    output logic                              take,
    output logic [$clog2(MAX_COLS)-1:0]       item_col,
    output logic [$clog2(MAX_ROWS+1)-1:0]     item_row,
    output glmf_pkg::item_flags_t             item_flags
);

    localparam int ROW_W  = $clog2(MAX_ROWS + 1);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int COLS_W = $clog2(MAX_COLS + 1);

    logic [ROW_W-1:0]  rows_reg, rows_next;
    logic [COLS_W-1:0] cols_reg, cols_next;
    logic [ROW_W-1:0]  row_count_reg, row_count_next;
    logic [COL_W-1:0]  col_count_reg, col_count_next;

    logic              accept;
    logic              last_col;
    logic [31:0]       cfg_wide;
    logic [ROW_W-1:0]  rows_clamp;
    logic [COLS_W-1:0] cols_clamp;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_wide = 32'(cfg_data);
        if (cfg_data == '0)
            rows_clamp = ROW_W'(1);
        else if (cfg_wide > 32'(MAX_ROWS))
            rows_clamp = ROW_W'(MAX_ROWS);
        else
            rows_clamp = ROW_W'(cfg_data);
        if (cfg_data == '0)
            cols_clamp = COLS_W'(1);
        else if (cfg_wide > 32'(MAX_COLS))
            cols_clamp = COLS_W'(MAX_COLS);
        else
            cols_clamp = COLS_W'(cfg_data);
    end

    always_comb
    begin
        accept   = pixel_valid && !pixel_stall;
        last_col = (COLS_W'(col_count_reg) + COLS_W'(1)) >= cols_reg;
        take     = accept && (op ? (row_count_reg == rows_reg) : (row_count_reg < rows_reg));

        item_col             = col_count_reg;
        item_row             = row_count_reg - ROW_W'(1);
        item_flags.flush     = op;
        item_flags.decide    = row_count_reg != '0;
        item_flags.has_up    = row_count_reg >= ROW_W'(2);
        item_flags.has_left  = col_count_reg != '0;
        item_flags.has_right = !last_col;

        rows_next      = rows_reg;
        cols_next      = cols_reg;
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                glmf_pkg::CFG_NUM_ROWS:
                begin
                    rows_next      = rows_clamp;
                    row_count_next = '0;
                    col_count_next = '0;
                end
                glmf_pkg::CFG_NUM_COLS:
                begin
                    cols_next      = cols_clamp;
                    row_count_next = '0;
                    col_count_next = '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (take)
        begin
            if (last_col)
            begin
                col_count_next = '0;
                row_count_next = op ? '0 : row_count_reg + ROW_W'(1);
            end
            else
            begin
                col_count_next = col_count_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg      <= ROW_W'(1);
            cols_reg      <= COLS_W'(1);
            row_count_reg <= '0;
            col_count_reg <= '0;
        end
        else
        begin
            rows_reg      <= rows_next;
            cols_reg      <= cols_next;
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
        end
    end

`ifndef SYNTHESIS
    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        COLS_W'(col_count_reg) < cols_reg)
        else $error("column counter past row end");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_count_reg <= rows_reg)
        else $error("row counter past flush phase");

    a_dims_legal: assert property (@(posedge clk) disable iff (!rst_n)
        rows_reg != '0 && cols_reg != '0 && 32'(rows_reg) <= 32'(MAX_ROWS)
        && 32'(cols_reg) <= 32'(MAX_COLS))
        else $error("grid dimensions out of range");
`endif

endmodule

// ===== rtl/glmf_line_bufs.sv =====
module glmf_line_bufs #(
    parameter int MAX_COLS    = 512,
    parameter int VALUE_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [$clog2(MAX_COLS)-1:0]   rd_col,
    input  logic                          wr_en,
    input  logic [$clog2(MAX_COLS)-1:0]   wr_col,
    input  logic signed [VALUE_WIDTH-1:0] wr_center,
    input  logic signed [VALUE_WIDTH-1:0] wr_upper,
    output logic signed [VALUE_WIDTH-1:0] mid,
    output logic signed [VALUE_WIDTH-1:0] up,
    output logic signed [VALUE_WIDTH-1:0] right
);

    localparam int COL_W = $clog2(MAX_COLS);

    logic signed [VALUE_WIDTH-1:0] center_line_mem [MAX_COLS];
    logic signed [VALUE_WIDTH-1:0] upper_line_mem  [MAX_COLS];

    logic signed [VALUE_WIDTH-1:0] center_a_reg;
    logic signed [VALUE_WIDTH-1:0] center_b_reg;
    logic signed [VALUE_WIDTH-1:0] upper_rd_reg;
    logic signed [VALUE_WIDTH-1:0] fwd_center_reg;
    logic signed [VALUE_WIDTH-1:0] fwd_upper_reg;
    logic                          fwd_mid_reg;
    logic                          fwd_right_reg;
    logic [COL_W-1:0]              rd_right;

    assign rd_right = rd_col + COL_W'(1);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            center_line_mem[wr_col] <= wr_center;
            upper_line_mem[wr_col]  <= wr_upper;
        end
        if (rd_en)
        begin
            center_a_reg   <= center_line_mem[rd_col];
            center_b_reg   <= center_line_mem[rd_right];
            upper_rd_reg   <= upper_line_mem[rd_col];
            fwd_center_reg <= wr_center;
            fwd_upper_reg  <= wr_upper;
        end
    end

    // write in the same cycle as the read: take the new data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_mid_reg   <= 1'b0;
            fwd_right_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_mid_reg   <= wr_en && (wr_col == rd_col);
            fwd_right_reg <= wr_en && (wr_col == rd_right);
        end
    end

    assign mid   = fwd_mid_reg   ? fwd_center_reg : center_a_reg;
    assign up    = fwd_mid_reg   ? fwd_upper_reg  : upper_rd_reg;
    assign right = fwd_right_reg ? fwd_center_reg : center_b_reg;

endmodule

// ===== rtl/glmf_peak_eval.sv =====
module glmf_peak_eval #(
    parameter int MAX_ROWS    = 512,
    parameter int MAX_COLS    = 512,
    parameter int VALUE_WIDTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              take,
    input  logic [$clog2(MAX_COLS)-1:0]       item_col,
    input  logic [$clog2(MAX_ROWS+1)-1:0]     item_row,
    input  glmf_pkg::item_flags_t             item_flags,
    input  logic signed [VALUE_WIDTH-1:0]     pixel_value,
    input  logic signed [VALUE_WIDTH-1:0]     mid,
    input  logic signed [VALUE_WIDTH-1:0]     up,
    input  logic signed [VALUE_WIDTH-1:0]     right,
    output logic                              pixel_stall,
    output logic                              wr_en,
    output logic [$clog2(MAX_COLS)-1:0]       wr_col,
    output logic signed [VALUE_WIDTH-1:0]     wr_center,
    output logic signed [VALUE_WIDTH-1:0]     wr_upper,
    output logic                              peak_valid,
    input  logic                              peak_stall,
    output logic [glmf_pkg::PEAK_W-1:0]       peak_row,
    output logic [glmf_pkg::PEAK_W-1:0]       peak_col
);

    localparam int ROW_W = $clog2(MAX_ROWS + 1);
    localparam int COL_W = $clog2(MAX_COLS);

    logic                          s1_valid_reg;
    logic [COL_W-1:0]              s1_col_reg;
    logic [ROW_W-1:0]              s1_row_reg;
    glmf_pkg::item_flags_t         s1_flags_reg;
    logic signed [VALUE_WIDTH-1:0] s1_down_reg;
    logic signed [VALUE_WIDTH-1:0] left_reg;
    logic                          out_valid_reg;
    logic [glmf_pkg::PEAK_W-1:0]   peak_row_reg;
    logic [glmf_pkg::PEAK_W-1:0]   peak_col_reg;

    logic                          adv;
    logic                          peak;

    always_comb
    begin
        adv         = s1_valid_reg && (!out_valid_reg || !peak_stall);
        pixel_stall = s1_valid_reg && !adv;

        peak = s1_flags_reg.decide;
        if (s1_flags_reg.has_up && (mid < up))
            peak = 1'b0;
        if (!s1_flags_reg.flush && (mid < s1_down_reg))
            peak = 1'b0;
        if (s1_flags_reg.has_left && (mid < left_reg))
            peak = 1'b0;
        if (s1_flags_reg.has_right && (mid < right))
            peak = 1'b0;

        wr_en     = adv && !s1_flags_reg.flush;
        wr_col    = s1_col_reg;
        wr_center = s1_down_reg;
        wr_upper  = mid;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_col_reg   <= item_col;
            s1_row_reg   <= item_row;
            s1_flags_reg <= item_flags;
            s1_down_reg  <= pixel_value;
        end
        if (adv && peak)
        begin
            peak_row_reg <= glmf_pkg::PEAK_W'(s1_row_reg);
            peak_col_reg <= glmf_pkg::PEAK_W'(s1_col_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            left_reg      <= '0;
        end
        else
        begin
            if (take)
                s1_valid_reg <= 1'b1;
            else if (adv)
                s1_valid_reg <= 1'b0;

            if (adv && peak)
                out_valid_reg <= 1'b1;
            else if (!peak_stall)
                out_valid_reg <= 1'b0;

            if (adv)
                left_reg <= mid;
        end
    end

    assign peak_valid = out_valid_reg;
    assign peak_row   = peak_row_reg;
    assign peak_col   = peak_col_reg;

`ifndef SYNTHESIS
    a_peak_from_decide: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg && s1_flags_reg.decide))
        else $error("result raised without a decided cell");

    a_no_write_on_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_flags_reg.flush) |-> !wr_en)
        else $error("line buffer written by a flush request");
`endif

endmodule

// ===== rtl/grid_local_maximum_finder.sv =====
// Channel  Handshake                 Payload
// -------  ------------------------  ------------------------------
// pixel    pixel_valid / pixel_stall op, pixel_value
// peak     peak_valid  / peak_stall  peak_row, peak_col
// cfg      cfg_valid   / cfg_ready   cfg_index, cfg_data
//
// One request per cycle unless stalled; a result is registered after evaluation.
// The rate is set by the evaluate stage: one read of each line buffer
// (two ports on the center line) and one write back per cycle.
// Reset clears counters, sets both dimensions to one; line buffers are not cleared.
// A held result stalls the evaluate stage, which then stalls pixel requests.
module grid_local_maximum_finder #(
    parameter int MAX_COLS    = 512,
    parameter int MAX_ROWS    = 512,
    parameter int VALUE_WIDTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  glmf_pkg::cfg_index_t            cfg_index,
    input  logic [glmf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            pixel_valid,
    output logic                            pixel_stall,
    input  logic                            op,
    input  logic signed [VALUE_WIDTH-1:0]   pixel_value,
    output logic                            peak_valid,
    input  logic                            peak_stall,
    output logic [glmf_pkg::PEAK_W-1:0]     peak_row,
    output logic [glmf_pkg::PEAK_W-1:0]     peak_col
);

    localparam int ROW_W = $clog2(MAX_ROWS + 1);
    localparam int COL_W = $clog2(MAX_COLS);

    logic                          take;
    logic [COL_W-1:0]              item_col;
    logic [ROW_W-1:0]              item_row;
    glmf_pkg::item_flags_t         item_flags;
    logic                          wr_en;
    logic [COL_W-1:0]              wr_col;
    logic signed [VALUE_WIDTH-1:0] wr_center;
    logic signed [VALUE_WIDTH-1:0] wr_upper;
    logic signed [VALUE_WIDTH-1:0] mid;
    logic signed [VALUE_WIDTH-1:0] up;
    logic signed [VALUE_WIDTH-1:0] right;

    glmf_frame_ctrl #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_valid (pixel_valid),
        .op          (op),
        .pixel_stall (pixel_stall),
        .take        (take),
        .item_col    (item_col),
        .item_row    (item_row),
        .item_flags  (item_flags)
    );

    glmf_line_bufs #(
        .MAX_COLS    (MAX_COLS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_bufs (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (take),
        .rd_col    (item_col),
        .wr_en     (wr_en),
        .wr_col    (wr_col),
        .wr_center (wr_center),
        .wr_upper  (wr_upper),
        .mid       (mid),
        .up        (up),
        .right     (right)
    );

    glmf_peak_eval #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_eval (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .item_col    (item_col),
        .item_row    (item_row),
        .item_flags  (item_flags),
        .pixel_value (pixel_value),
        .mid         (mid),
        .up          (up),
        .right       (right),
        .pixel_stall (pixel_stall),
        .wr_en       (wr_en),
        .wr_col      (wr_col),
        .wr_center   (wr_center),
        .wr_upper    (wr_upper),
        .peak_valid  (peak_valid),
        .peak_stall  (peak_stall),
        .peak_row    (peak_row),
        .peak_col    (peak_col)
    );

endmodule
